@@ sv/capf_pkg.sv @@
package capf_pkg;

    localparam logic [7:0] ENVELOPE_TAG = 8'h0B;
    localparam logic [7:0] CLASS_PLAIN = 8'h00;
    localparam logic [7:0] CLASS_PROPRIETARY = 8'h80;
    localparam logic [7:0] CLASS_SECURE = 8'h84;
    localparam logic [7:0] SHORT_MAX = 8'hFF;

    localparam logic OP_HEADER = 1'b0;
    localparam logic OP_DATA = 1'b1;

    typedef enum logic [1:0] {
        STATUS_OK = 2'd0,
        STATUS_CLASS = 2'd1,
        STATUS_UNEXPECTED = 2'd2
    } status_t;

    typedef enum logic [4:0] {
        ST_IDLE,
        ST_ENV_TAG,
        ST_ENV_HI,
        ST_ENV_LO,
        ST_CLA,
        ST_INS,
        ST_P1,
        ST_P2,
        ST_LC_EXT0,
        ST_LC_HI,
        ST_LC_LO,
        ST_DATA,
        ST_LE_EXT0,
        ST_LE_HI,
        ST_LE_LO,
        ST_ERR_CLASS,
        ST_ERR_DATA
    } state_t;

    typedef enum logic [3:0] {
        SEL_ZERO,
        SEL_TAG,
        SEL_SIZE_HI,
        SEL_SIZE_LO,
        SEL_CLA,
        SEL_INS,
        SEL_P1,
        SEL_P2,
        SEL_LC_HI,
        SEL_LC_LO,
        SEL_DATA,
        SEL_LE_HI,
        SEL_LE_LO
    } byte_sel_t;

    typedef struct packed {
        logic      hdr_accept;
        logic      data_accept;
        logic      load;
        byte_sel_t sel;
        logic      last;
        status_t   status;
    } ctrl_cmd_t;

    typedef struct packed {
        logic out_free;
        logic reject;
        logic env_en;
        logic rem_zero;
        logic discard;
        logic lc_zero;
        logic lc_ext;
        logic le_zero;
        logic le_short;
    } dp_status_t;

    // Size in bytes of the Le field for a given Le and length mode.
    function automatic logic [2:0] le_field_size(input logic [15:0] le, input logic ext);
        logic [2:0] size;
        if (le == 16'd0) begin
            size = 3'd0;
        end else if (ext) begin
            size = 3'd2;
        end else if (le <= {8'd0, SHORT_MAX}) begin
            size = 3'd1;
        end else begin
            size = 3'd3;
        end
        return size;
    endfunction

endpackage

@@ sv/command_apdu_framer_core.sv @@
// Command APDU framer. A header word yields the envelope prefix when enabled
// (tag, length high, length low), the four header bytes and the Lc field; each
// data word yields one byte, and the Le field follows the last data byte or
// the header when there is no data. The controller takes a word only while it
// is idle and then emits one byte per cycle into a single output register,
// each byte waiting while that register is held by the downstream side. A
// header word emits four to ten bytes, a passed data word one byte plus up to
// three more for a trailing Le field, an error word one byte and a swallowed
// data word none.
module command_apdu_framer_core (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_we,
    input  logic        cfg_wdata,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic        s_operation,
    input  logic [7:0]  s_class_byte,
    input  logic [7:0]  s_instruction_byte,
    input  logic [7:0]  s_param_one,
    input  logic [7:0]  s_param_two,
    input  logic [15:0] s_data_length,
    input  logic [15:0] s_expected_length,
    input  logic [7:0]  s_data_byte,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [7:0]  m_wire_byte,
    output logic        m_last_byte,
    output logic [1:0]  m_status
);

    capf_pkg::ctrl_cmd_t  cmd;
    capf_pkg::dp_status_t sts;

    capf_ctrl u_ctrl (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_valid     (s_valid),
        .s_operation (s_operation),
        .s_ready     (s_ready),
        .sts         (sts),
        .cmd         (cmd)
    );

    capf_datapath u_datapath (
        .aclk               (aclk),
        .aresetn            (aresetn),
        .cfg_we             (cfg_we),
        .cfg_wdata          (cfg_wdata),
        .s_class_byte       (s_class_byte),
        .s_instruction_byte (s_instruction_byte),
        .s_param_one        (s_param_one),
        .s_param_two        (s_param_two),
        .s_data_length      (s_data_length),
        .s_expected_length  (s_expected_length),
        .s_data_byte        (s_data_byte),
        .cmd                (cmd),
        .sts                (sts),
        .m_valid            (m_valid),
        .m_ready            (m_ready),
        .m_wire_byte        (m_wire_byte),
        .m_last_byte        (m_last_byte),
        .m_status           (m_status)
    );

endmodule

@@ sv/capf_datapath.sv @@
module capf_datapath (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  cfg_we,
    input  logic                  cfg_wdata,
    input  logic [7:0]            s_class_byte,
    input  logic [7:0]            s_instruction_byte,
    input  logic [7:0]            s_param_one,
    input  logic [7:0]            s_param_two,
    input  logic [15:0]           s_data_length,
    input  logic [15:0]           s_expected_length,
    input  logic [7:0]            s_data_byte,
    input  capf_pkg::ctrl_cmd_t   cmd,
    output capf_pkg::dp_status_t  sts,
    output logic                  m_valid,
    input  logic                  m_ready,
    output logic [7:0]            m_wire_byte,
    output logic                  m_last_byte,
    output logic [1:0]            m_status
);

    logic        env_en_reg;
    logic [7:0]  cla_reg;
    logic [7:0]  ins_reg;
    logic [7:0]  p1_reg;
    logic [7:0]  p2_reg;
    logic [15:0] lc_reg;
    logic [15:0] le_reg;
    logic [15:0] rem_reg;
    logic [15:0] rem_next;
    logic        discard_reg;
    logic        discard_next;
    logic [15:0] size_reg;
    logic [15:0] size_next;
    logic [7:0]  data_reg;
    logic        m_valid_reg;
    logic [7:0]  m_byte_reg;
    logic        m_last_reg;
    logic [1:0]  m_status_reg;
    logic [7:0]  byte_mux;
    logic        class_ok;
    logic        in_lc_zero;
    logic        in_ext;
    logic [2:0]  in_extra;

    assign class_ok = (s_class_byte == capf_pkg::CLASS_PLAIN)
                   || (s_class_byte == capf_pkg::CLASS_PROPRIETARY)
                   || (s_class_byte == capf_pkg::CLASS_SECURE);

    assign in_lc_zero = (s_data_length == 16'd0);
    assign in_ext = (s_data_length > {8'd0, capf_pkg::SHORT_MAX});

    always_comb begin
        if (in_lc_zero) begin
            in_extra = capf_pkg::le_field_size(s_expected_length, 1'b0);
        end else begin
            in_extra = (in_ext ? 3'd3 : 3'd1)
                     + capf_pkg::le_field_size(s_expected_length, in_ext);
        end
        size_next = 16'd4 + s_data_length + {13'd0, in_extra};
    end

    always_comb begin
        rem_next = rem_reg;
        discard_next = discard_reg;
        if (cmd.hdr_accept) begin
            rem_next = s_data_length;
            discard_next = sts.reject && !in_lc_zero;
        end else if (cmd.data_accept && (rem_reg != 16'd0)) begin
            rem_next = rem_reg - 16'd1;
            if (rem_reg == 16'd1) begin
                discard_next = 1'b0;
            end
        end
    end

    always_comb begin
        case (cmd.sel)
            capf_pkg::SEL_ZERO:    byte_mux = 8'h00;
            capf_pkg::SEL_TAG:     byte_mux = capf_pkg::ENVELOPE_TAG;
            capf_pkg::SEL_SIZE_HI: byte_mux = size_reg[15:8];
            capf_pkg::SEL_SIZE_LO: byte_mux = size_reg[7:0];
            capf_pkg::SEL_CLA:     byte_mux = cla_reg;
            capf_pkg::SEL_INS:     byte_mux = ins_reg;
            capf_pkg::SEL_P1:      byte_mux = p1_reg;
            capf_pkg::SEL_P2:      byte_mux = p2_reg;
            capf_pkg::SEL_LC_HI:   byte_mux = lc_reg[15:8];
            capf_pkg::SEL_LC_LO:   byte_mux = lc_reg[7:0];
            capf_pkg::SEL_DATA:    byte_mux = data_reg;
            capf_pkg::SEL_LE_HI:   byte_mux = le_reg[15:8];
            capf_pkg::SEL_LE_LO:   byte_mux = le_reg[7:0];
            default:               byte_mux = 8'h00;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            env_en_reg <= 1'b0;
            rem_reg <= 16'd0;
            discard_reg <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            if (cfg_we) begin
                env_en_reg <= cfg_wdata;
            end
            rem_reg <= rem_next;
            discard_reg <= discard_next;
            if (cmd.load) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.hdr_accept) begin
            cla_reg <= s_class_byte;
            ins_reg <= s_instruction_byte;
            p1_reg <= s_param_one;
            p2_reg <= s_param_two;
            lc_reg <= s_data_length;
            le_reg <= s_expected_length;
            size_reg <= size_next;
        end
        if (cmd.data_accept) begin
            data_reg <= s_data_byte;
        end
        if (cmd.load) begin
            m_byte_reg <= byte_mux;
            m_last_reg <= cmd.last;
            m_status_reg <= cmd.status;
        end
    end

    assign sts.out_free = !m_valid_reg || m_ready;
    assign sts.reject = env_en_reg && !class_ok;
    assign sts.env_en = env_en_reg;
    assign sts.rem_zero = (rem_reg == 16'd0);
    assign sts.discard = discard_reg;
    assign sts.lc_zero = (lc_reg == 16'd0);
    assign sts.lc_ext = (lc_reg > {8'd0, capf_pkg::SHORT_MAX});
    assign sts.le_zero = (le_reg == 16'd0);
    assign sts.le_short = (le_reg <= {8'd0, capf_pkg::SHORT_MAX});

    assign m_valid = m_valid_reg;
    assign m_wire_byte = m_byte_reg;
    assign m_last_byte = m_last_reg;
    assign m_status = m_status_reg;

endmodule

@@ sv/capf_ctrl.sv @@
module capf_ctrl (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_valid,
    input  logic                  s_operation,
    output logic                  s_ready,
    input  capf_pkg::dp_status_t  sts,
    output capf_pkg::ctrl_cmd_t   cmd
);

    capf_pkg::state_t state_reg;
    capf_pkg::state_t state_next;
    capf_pkg::state_t le_start;
    logic             accept;

    assign s_ready = (state_reg == capf_pkg::ST_IDLE);
    assign accept = s_valid && s_ready;

    always_comb begin
        if (sts.lc_ext) begin
            le_start = capf_pkg::ST_LE_HI;
        end else if (sts.le_short) begin
            le_start = capf_pkg::ST_LE_LO;
        end else begin
            le_start = capf_pkg::ST_LE_EXT0;
        end
    end

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            capf_pkg::ST_IDLE: begin
                if (s_valid) begin
                    if (s_operation == capf_pkg::OP_HEADER) begin
                        if (sts.reject) begin
                            state_next = capf_pkg::ST_ERR_CLASS;
                        end else if (sts.env_en) begin
                            state_next = capf_pkg::ST_ENV_TAG;
                        end else begin
                            state_next = capf_pkg::ST_CLA;
                        end
                    end else if (sts.rem_zero) begin
                        state_next = capf_pkg::ST_ERR_DATA;
                    end else if (!sts.discard) begin
                        state_next = capf_pkg::ST_DATA;
                    end
                end
            end
            default: begin
                if (sts.out_free) begin
                    case (state_reg)
                        capf_pkg::ST_ENV_TAG: state_next = capf_pkg::ST_ENV_HI;
                        capf_pkg::ST_ENV_HI:  state_next = capf_pkg::ST_ENV_LO;
                        capf_pkg::ST_ENV_LO:  state_next = capf_pkg::ST_CLA;
                        capf_pkg::ST_CLA:     state_next = capf_pkg::ST_INS;
                        capf_pkg::ST_INS:     state_next = capf_pkg::ST_P1;
                        capf_pkg::ST_P1:      state_next = capf_pkg::ST_P2;
                        capf_pkg::ST_P2: begin
                            if (sts.lc_zero) begin
                                state_next = sts.le_zero ? capf_pkg::ST_IDLE : le_start;
                            end else if (sts.lc_ext) begin
                                state_next = capf_pkg::ST_LC_EXT0;
                            end else begin
                                state_next = capf_pkg::ST_LC_LO;
                            end
                        end
                        capf_pkg::ST_LC_EXT0: state_next = capf_pkg::ST_LC_HI;
                        capf_pkg::ST_LC_HI:   state_next = capf_pkg::ST_LC_LO;
                        capf_pkg::ST_DATA: begin
                            if (sts.rem_zero && !sts.le_zero) begin
                                state_next = le_start;
                            end else begin
                                state_next = capf_pkg::ST_IDLE;
                            end
                        end
                        capf_pkg::ST_LE_EXT0: state_next = capf_pkg::ST_LE_HI;
                        capf_pkg::ST_LE_HI:   state_next = capf_pkg::ST_LE_LO;
                        default:              state_next = capf_pkg::ST_IDLE;
                    endcase
                end
            end
        endcase
    end

    always_comb begin
        cmd.hdr_accept = accept && (s_operation == capf_pkg::OP_HEADER);
        cmd.data_accept = accept && (s_operation == capf_pkg::OP_DATA);
        cmd.load = sts.out_free && (state_reg != capf_pkg::ST_IDLE);
        cmd.last = 1'b0;
        cmd.status = capf_pkg::STATUS_OK;
        case (state_reg)
            capf_pkg::ST_ENV_TAG: cmd.sel = capf_pkg::SEL_TAG;
            capf_pkg::ST_ENV_HI:  cmd.sel = capf_pkg::SEL_SIZE_HI;
            capf_pkg::ST_ENV_LO:  cmd.sel = capf_pkg::SEL_SIZE_LO;
            capf_pkg::ST_CLA:     cmd.sel = capf_pkg::SEL_CLA;
            capf_pkg::ST_INS:     cmd.sel = capf_pkg::SEL_INS;
            capf_pkg::ST_P1:      cmd.sel = capf_pkg::SEL_P1;
            capf_pkg::ST_P2: begin
                cmd.sel = capf_pkg::SEL_P2;
                cmd.last = sts.lc_zero && sts.le_zero;
            end
            capf_pkg::ST_LC_EXT0: cmd.sel = capf_pkg::SEL_ZERO;
            capf_pkg::ST_LC_HI:   cmd.sel = capf_pkg::SEL_LC_HI;
            capf_pkg::ST_LC_LO:   cmd.sel = capf_pkg::SEL_LC_LO;
            capf_pkg::ST_DATA: begin
                cmd.sel = capf_pkg::SEL_DATA;
                cmd.last = sts.rem_zero && sts.le_zero;
            end
            capf_pkg::ST_LE_EXT0: cmd.sel = capf_pkg::SEL_ZERO;
            capf_pkg::ST_LE_HI:   cmd.sel = capf_pkg::SEL_LE_HI;
            capf_pkg::ST_LE_LO: begin
                cmd.sel = capf_pkg::SEL_LE_LO;
                cmd.last = 1'b1;
            end
            capf_pkg::ST_ERR_CLASS: begin
                cmd.sel = capf_pkg::SEL_ZERO;
                cmd.last = 1'b1;
                cmd.status = capf_pkg::STATUS_CLASS;
            end
            capf_pkg::ST_ERR_DATA: begin
                cmd.sel = capf_pkg::SEL_ZERO;
                cmd.last = 1'b1;
                cmd.status = capf_pkg::STATUS_UNEXPECTED;
            end
            default: cmd.sel = capf_pkg::SEL_ZERO;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= capf_pkg::ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

endmodule
